// File: rtl/thi_pkg.sv
// ----------------------------------------------------------------------------
// thi_pkg
// Shared widths, codes and reset values of the thermistor table interpolator.
// ----------------------------------------------------------------------------
package thi_pkg;

   localparam int IDX_W       = 8;   // entry_index
   localparam int TEMP_W      = 10;  // whole-degree temperatures
   localparam int LEN_W       = 9;   // table_length register
   localparam int FRAC_W      = 8;   // fraction bits of the result
   localparam int Q_W         = 18;  // temperature_q8
   localparam int STATUS_W    = 2;   // clamp_status
   localparam int OUT_TDATA_W = 24;  // Q_W rounded up to whole bytes
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   // command codes (req_tuser)
   localparam logic CMD_WRITE   = 1'b0;
   localparam logic CMD_CONVERT = 1'b1;

   // clamp status codes (rsp_tuser)
   localparam logic [STATUS_W-1:0] CLAMP_NONE = 2'd0;
   localparam logic [STATUS_W-1:0] CLAMP_LOW  = 2'd1;
   localparam logic [STATUS_W-1:0] CLAMP_HIGH = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_TABLE_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FALLING      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LOW_CLAMP    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_CLAMP   = 2'd3;

   // register reset values
   localparam logic [LEN_W-1:0]         RST_TABLE_LENGTH = 9'd24;
   localparam logic                     RST_FALLING      = 1'b0;
   localparam logic signed [TEMP_W-1:0] RST_LOW_CLAMP    = -10'sd55;
   localparam logic signed [TEMP_W-1:0] RST_HIGH_CLAMP   = 10'sd150;

   // divider handback
   typedef struct packed {
      logic           done;
      logic [Q_W-1:0] quotient;
   } thi_div_result_type;

endpackage

// File: rtl/thermistor_table_interpolator_top.sv
// ----------------------------------------------------------------------------
// thermistor_table_interpolator_top
// Resistance to temperature conversion over a loaded calibration table with
// linear interpolation between bracketing entries.
//
//   channel | dir | handshake               | carries
//   req_    | in  | req_tvalid / req_tready | table write or convert request
//   rsp_    | out | rsp_tvalid / rsp_tready | converted temperature, status
//   csr_    | in  | csr_valid / csr_ready   | register index and write data
//
// A write transaction stores one entry and leaves the block ready for
// the next request. A convert walks the table through the RAM read
// port, one entry a cycle, then uses the shared multiplier twice and
// the serial divider.
// Reset is synchronous and restores the register defaults; table contents
// are not cleared. A stalled rsp_ channel holds one finished result and the
// block keeps taking requests; a convert finishing meanwhile waits for it.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator_top
   import thi_pkg::*;
#(
   parameter int TABLE_DEPTH      = 256,
   parameter int RESISTANCE_WIDTH = 16
) (
   input  logic                                            clock,
   input  logic                                            reset,
   // request: tdata = entry_index, resistance, entry_temperature (low bit up)
   input  logic                                            req_tvalid,
   output logic                                            req_tready,
   input  logic [((IDX_W+RESISTANCE_WIDTH+TEMP_W+7)/8)*8-1:0] req_tdata,
   input  logic                                            req_tuser,  // command
   // response: tdata = temperature_q8
   output logic                                            rsp_tvalid,
   input  logic                                            rsp_tready,
   output logic [OUT_TDATA_W-1:0]                          rsp_tdata,
   output logic [STATUS_W-1:0]                             rsp_tuser,  // clamp_status
   // register writes
   input  logic                                            csr_valid,
   output logic                                            csr_ready,
   input  logic [CSR_INDEX_W-1:0]                          csr_index,
   input  logic [CSR_DATA_W-1:0]                           csr_data
);

   localparam int RW    = RESISTANCE_WIDTH;
   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int LW    = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
   localparam int ENT_W = RW + TEMP_W;
   localparam int PW    = RW + TEMP_W + 2;
   localparam int NW    = PW + FRAC_W + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_MUL1  = 3'd3;
   localparam logic [2:0] S_MUL2  = 3'd4;
   localparam logic [2:0] S_SUM   = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   // request fields
   logic [IDX_W-1:0]         in_idx;
   logic [RW-1:0]            in_res;
   logic signed [TEMP_W-1:0] in_temp;
   logic                     req_accept;

   assign in_idx     = req_tdata[IDX_W-1:0];
   assign in_res     = req_tdata[IDX_W+RW-1:IDX_W];
   assign in_temp    = req_tdata[IDX_W+RW+TEMP_W-1:IDX_W+RW];
   assign req_accept = req_tvalid && req_tready;

   // registers
   logic [LEN_W-1:0]         len_ff;
   logic                     falling_ff;
   logic signed [TEMP_W-1:0] low_clamp_ff;
   logic signed [TEMP_W-1:0] high_clamp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= RST_TABLE_LENGTH;
         falling_ff    <= RST_FALLING;
         low_clamp_ff  <= RST_LOW_CLAMP;
         high_clamp_ff <= RST_HIGH_CLAMP;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TABLE_LENGTH: len_ff        <= csr_data[LEN_W-1:0];
            REG_FALLING:      falling_ff    <= csr_data[0];
            REG_LOW_CLAMP:    low_clamp_ff  <= csr_data;
            REG_HIGH_CLAMP:   high_clamp_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [LW-1:0] len_eff;
   assign len_eff = (32'(len_ff) > TABLE_DEPTH) ? LW'(TABLE_DEPTH) : LW'(len_ff);

   // sequencer state
   logic [2:0]               state_ff, state_in;
   logic [AW-1:0]            k_ff, k_in;
   logic [RW-1:0]            r_ff, r_in;
   logic [RW-1:0]            prev_res_ff, prev_res_in;
   logic signed [TEMP_W-1:0] prev_temp_ff, prev_temp_in;
   logic [RW-1:0]            d_ff, d_in;
   logic [RW-1:0]            n_ff, n_in;
   logic signed [TEMP_W-1:0] t0_ff, t0_in;
   logic signed [TEMP_W:0]   dt_ff, dt_in;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic signed [PW-1:0]     acc_ff, acc_in;
   logic                     neg_ff, neg_in;
   logic [NW-1:0]            mag_ff, mag_in;
   logic [Q_W-1:0]           result_ff, result_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [Q_W-1:0]           rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]      rsp_user_ff, rsp_user_in;
   logic                     div_kick_ff;

   // table RAM: resistance in the low bits, temperature above
   logic                     wr_en;
   logic [AW-1:0]            rd_addr;
   logic [ENT_W-1:0]         rd_data;
   logic [RW-1:0]            ent_res;
   logic signed [TEMP_W-1:0] ent_temp;
   logic [AW:0]              k_next;

   assign wr_en    = req_accept && (req_tuser == CMD_WRITE)
                     && (32'(in_idx) < TABLE_DEPTH);
   assign k_next   = {1'b0, k_ff} + (AW+1)'(1);
   assign rd_addr  = (state_ff == S_SCAN) ? k_next[AW-1:0] : '0;
   assign ent_res  = rd_data[RW-1:0];
   assign ent_temp = rd_data[ENT_W-1:RW];

   thi_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(in_idx)),
      .wr_data ({in_temp, in_res}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared multiplier: t0 * d first, then n * dt
   logic signed [RW:0]     mul_a;
   logic signed [TEMP_W:0] mul_b;
   logic signed [PW-1:0]   mul_p;

   assign mul_a = (state_ff == S_MUL1) ? $signed({1'b0, d_ff}) : $signed({1'b0, n_ff});
   assign mul_b = (state_ff == S_MUL1) ? $signed({t0_ff[TEMP_W-1], t0_ff}) : dt_ff;
   assign mul_p = PW'(mul_a) * PW'(mul_b);

   // serial divider
   logic               div_start;
   logic [NW-1:0]      dividend;
   thi_div_result_type div_res;

   assign dividend = {mag_ff[NW-FRAC_W-1:0], {FRAC_W{1'b0}}};

   thi_divider #(
      .DIVIDEND_W (NW),
      .DIVISOR_W  (RW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (d_ff),
      .result   (div_res)
   );

   logic                 beyond;
   logic                 out_free;
   logic signed [NW-1:0] sum;

   assign beyond   = falling_ff ? (r_ff < ent_res) : (r_ff > ent_res);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign sum      = NW'(acc_ff) + NW'(prod_ff);

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      prev_res_in  = prev_res_ff;
      prev_temp_in = prev_temp_ff;
      d_in         = d_ff;
      n_in         = n_ff;
      t0_in        = t0_ff;
      dt_in        = dt_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      result_in    = result_ff;
      status_in    = status_ff;
      div_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_tuser == CMD_CONVERT)) begin
               r_in     = in_res;
               k_in     = '0;
               state_in = S_START;
            end
         end
         S_START: begin
            // entry 0 is being read
            if (len_eff == '0) begin
               result_in = {high_clamp_ff, {FRAC_W{1'b0}}};
               status_in = CLAMP_HIGH;
               state_in  = S_OUT;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!beyond) begin
               if (k_ff == '0) begin
                  result_in = {low_clamp_ff, {FRAC_W{1'b0}}};
                  status_in = CLAMP_LOW;
                  state_in  = S_OUT;
               end else begin
                  d_in     = falling_ff ? (prev_res_ff - ent_res) : (ent_res - prev_res_ff);
                  n_in     = falling_ff ? (prev_res_ff - r_ff) : (r_ff - prev_res_ff);
                  t0_in    = prev_temp_ff;
                  dt_in    = $signed({ent_temp[TEMP_W-1], ent_temp})
                             - $signed({prev_temp_ff[TEMP_W-1], prev_temp_ff});
                  state_in = S_MUL1;
               end
            end else if (LW'(k_next) >= len_eff) begin
               result_in = {high_clamp_ff, {FRAC_W{1'b0}}};
               status_in = CLAMP_HIGH;
               state_in  = S_OUT;
            end else begin
               prev_res_in  = ent_res;
               prev_temp_in = ent_temp;
               k_in         = k_next[AW-1:0];
            end
         end
         S_MUL1: begin
            prod_in  = mul_p;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            acc_in   = prod_ff;
            prod_in  = mul_p;
            state_in = S_SUM;
         end
         S_SUM: begin
            neg_in   = sum[NW-1];
            mag_in   = sum[NW-1] ? NW'(-sum) : NW'(sum);
            state_in = S_DIV;
         end
         S_DIV: begin
            // start pulse on entry: mag_ff has just settled
            div_start = div_kick_ff;
            if (div_res.done) begin
               result_in = neg_ff ? (Q_W'(0) - div_res.quotient) : div_res.quotient;
               status_in = CLAMP_NONE;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (state_ff == S_SUM) begin
         div_start = 1'b0;
      end
   end

   // kick the divider in the first S_DIV cycle, once the magnitude is registered
   always_ff @(posedge clock) begin
      if (reset) begin
         div_kick_ff <= 1'b0;
      end else begin
         div_kick_ff <= (state_ff == S_SUM);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if ((state_ff == S_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result_ff;
         rsp_user_in  = status_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      r_ff         <= r_in;
      prev_res_ff  <= prev_res_in;
      prev_temp_ff <= prev_temp_in;
      d_ff         <= d_in;
      n_ff         <= n_in;
      t0_ff        <= t0_in;
      dt_ff        <= dt_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      result_ff    <= result_in;
      status_ff    <= status_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(OUT_TDATA_W-Q_W){1'b0}}, rsp_data_ff};
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: rtl/thi_ram.sv
// ----------------------------------------------------------------------------
// thi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module thi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/thi_divider.sv
// ----------------------------------------------------------------------------
// thi_divider
// Restoring divider, one quotient bit a cycle. The caller guarantees that the
// quotient fits in Q_W bits, so only the low Q_W steps are run.
// ----------------------------------------------------------------------------
module thi_divider
   import thi_pkg::*;
#(
   parameter int DIVIDEND_W = 37,
   parameter int DIVISOR_W  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output thi_div_result_type    result
);

   localparam int CNT_W = $clog2(Q_W + 1);

   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [Q_W-1:0]       low_ff, low_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 ge;

   // low_ff feeds dividend bits out at the top and takes quotient bits in
   assign trial = {rem_ff, low_ff[Q_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = (trial >= {1'b0, div_ff});

   always_comb begin
      rem_in   = rem_ff;
      div_in   = div_ff;
      low_in   = low_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = DIVISOR_W'(dividend[DIVIDEND_W-1:Q_W]);
         low_in   = dividend[Q_W-1:0];
         div_in   = divisor;
         count_in = CNT_W'(Q_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         low_in   = {low_ff[Q_W-2:0], ge};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      low_ff <= low_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = low_ff;

endmodule

// File: rtl/thi_checker.sv
// ----------------------------------------------------------------------------
// thi_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module thi_checker
   import thi_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [OUT_TDATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]    rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transaction changed while stalled");

   // a convert leaves the block busy, not ready for a new request
   a_convert_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_CONVERT) |=> !req_tready)
      else $error("request taken straight after a convert");

   // the block stays ready after a table write
   a_write_quick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_WRITE) |=> req_tready)
      else $error("block not ready after a table write");

   // reset leaves the block empty and ready
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind thermistor_table_interpolator_top thi_checker u_thi_checker (.*);

// File: dv/thermistor_table_interpolator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thermistor_table_interpolator_top_tb
// Loads calibration tables through write transactions and converts readings
// against them. Rising and falling curves, clamp settings and table lengths
// change between phases. Conversions are predicted locally and checked
// against the rsp_ stream in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator_top_tb;
   import thi_pkg::*;

   localparam int DEPTH         = 256;
   localparam int RES_W         = 16;
   localparam int REQ_W         = ((IDX_W + RES_W + TEMP_W + 7) / 8) * 8;
   localparam int SETTLE_CYCLES = 300;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int ITEM_TARGET   = 1350;

   typedef struct {
      logic                     cmd;
      logic [IDX_W-1:0]         idx;
      logic [RES_W-1:0]         res;
      logic signed [TEMP_W-1:0] temp;
   } table_request_type;

   typedef struct {
      logic signed [Q_W-1:0] q8;
      logic [STATUS_W-1:0]   status;
   } conversion_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata  = '0;
   logic                   req_tuser  = CMD_WRITE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [OUT_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // local copy of the block's state and registers
   logic [RES_W-1:0]         res_tab [DEPTH];
   logic signed [TEMP_W-1:0] temp_tab[DEPTH];
   logic [LEN_W-1:0]         cfg_length  = RST_TABLE_LENGTH;
   logic                     cfg_falling = RST_FALLING;
   logic signed [TEMP_W-1:0] cfg_low     = RST_LOW_CLAMP;
   logic signed [TEMP_W-1:0] cfg_high    = RST_HIGH_CLAMP;

   table_request_type request_q[$];
   conversion_type    temp_results_q[$];
   table_request_type req_item;
   conversion_type    want;
   bit             req_free;
   bit             req_burst = 1'b0;
   bit             rsp_burst = 1'b0;
   int             req_gap   = 0;
   int             rsp_wait  = 0;
   int             rsp_draw;
   int             pushed_count   = 0;
   int             accepted_count = 0;
   int             fail_count     = 0;
   int             cycle_count    = 0;

   thermistor_table_interpolator_top #(
      .TABLE_DEPTH      (DEPTH),
      .RESISTANCE_WIDTH (RES_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // scan for the first entry at or beyond the reading, then clamp or interpolate
   function automatic conversion_type convert_reading(input logic [RES_W-1:0] r);
      conversion_type c;
      int unsigned span, k;
      longint      lo, hi, n, d, t0, dt, num;
      bit          past;
      span = (cfg_length > DEPTH) ? DEPTH : cfg_length;
      k = 0;
      while (k < span) begin
         past = cfg_falling ? (r < res_tab[k]) : (r > res_tab[k]);
         if (!past) break;
         k++;
      end
      if (k >= span) begin
         c.q8     = Q_W'(longint'(cfg_high) * 256);
         c.status = CLAMP_HIGH;
      end else if (k == 0) begin
         c.q8     = Q_W'(longint'(cfg_low) * 256);
         c.status = CLAMP_LOW;
      end else begin
         lo = longint'(res_tab[k-1]);
         hi = longint'(res_tab[k]);
         if (cfg_falling) begin
            d = lo - hi;
            n = lo - longint'(r);
         end else begin
            d = hi - lo;
            n = longint'(r) - lo;
         end
         if (d <= 0) d = 1;
         t0  = longint'(temp_tab[k-1]);
         dt  = longint'(temp_tab[k]) - t0;
         num = t0 * 256 * d + n * dt * 256;
         c.q8     = Q_W'(num / d);   // truncates toward zero
         c.status = CLAMP_NONE;
      end
      return c;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         req_free = !req_tvalid;
         if (req_tvalid && req_tready) begin
            accepted_count++;
            if (req_item.cmd == CMD_WRITE) begin
               res_tab[req_item.idx]  = req_item.res;
               temp_tab[req_item.idx] = req_item.temp;
            end else begin
               temp_results_q.push_back(convert_reading(req_item.res));
            end
            req_free = 1'b1;
         end
         if (req_free) begin
            if (req_gap != 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (request_q.size() != 0) begin
               req_item = request_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_W'({req_item.temp, req_item.res, req_item.idx});
               req_tuser  <= req_item.cmd;
               req_gap    <= req_burst ? 0 : $urandom_range(0, 17);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (temp_results_q.size() == 0) begin
            $display("%0t: unexpected result: temperature_q8 %0d clamp_status %0d", $time,
                     $signed(rsp_tdata[Q_W-1:0]), rsp_tuser);
            fail_count++;
         end else begin
            want = temp_results_q.pop_front();
            if (rsp_tdata[Q_W-1:0] !== want.q8) begin
               $display("%0t: temperature_q8 mismatch: expected %0d, actual %0d", $time,
                        want.q8, $signed(rsp_tdata[Q_W-1:0]));
               fail_count++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: clamp_status mismatch: expected %0d, actual %0d", $time,
                        want.status, rsp_tuser);
               fail_count++;
            end
         end
         rsp_draw = rsp_burst ? 0 : $urandom_range(0, 17);
         if (rsp_draw == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            rsp_wait   <= rsp_draw - 1;
         end
      end else if (!rsp_tready) begin
         if (rsp_wait == 0) rsp_tready <= 1'b1;
         else rsp_wait <= rsp_wait - 1;
      end
   end

   task automatic push_write(input logic [IDX_W-1:0] idx, input logic [RES_W-1:0] res,
                             input logic signed [TEMP_W-1:0] temp);
      table_request_type it;
      it.cmd  = CMD_WRITE;
      it.idx  = idx;
      it.res  = res;
      it.temp = temp;
      request_q.push_back(it);
      pushed_count++;
   endtask

   task automatic push_convert(input logic [RES_W-1:0] r);
      table_request_type it;
      it.cmd  = CMD_CONVERT;
      it.idx  = IDX_W'($urandom);   // don't-care on a convert
      it.res  = r;
      it.temp = TEMP_W'($urandom);
      request_q.push_back(it);
      pushed_count++;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (accepted_count != pushed_count || temp_results_q.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_TABLE_LENGTH: cfg_length  = data[LEN_W-1:0];
         REG_FALLING:      cfg_falling = data[0];
         REG_LOW_CLAMP:    cfg_low     = data;
         REG_HIGH_CLAMP:   cfg_high    = data;
         default: ;
      endcase
   endtask

   // registers change only with the block idle
   task automatic set_registers(input int len, input bit falling,
                                input logic signed [TEMP_W-1:0] low,
                                input logic signed [TEMP_W-1:0] high);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(REG_TABLE_LENGTH, CSR_DATA_W'(len));
      write_register(REG_FALLING, CSR_DATA_W'(falling));
      write_register(REG_LOW_CLAMP, low);
      write_register(REG_HIGH_CLAMP, high);
   endtask

   // reload the first entries, then convert; mostly monotonic tables
   task automatic run_phase(input int len, input int conversions);
      logic [RES_W-1:0]         vals[DEPTH];
      logic [RES_W-1:0]         tmin, tmax;
      logic signed [TEMP_W-1:0] lo_c, hi_c;
      int                       span, step_max, acc, pause_at, sel;
      bit                       falling, ordered;
      falling = 1'($urandom_range(0, 1));
      lo_c    = TEMP_W'($urandom);
      hi_c    = TEMP_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         lo_c = TEMP_W'(-512);
         hi_c = 10'sd511;
      end
      set_registers(len, falling, lo_c, hi_c);
      req_burst = ($urandom_range(0, 3) == 0);
      rsp_burst = ($urandom_range(0, 3) == 0);
      span     = (len > DEPTH) ? DEPTH : len;
      step_max = 65535 / span;
      ordered  = ($urandom_range(0, 5) != 0);
      acc      = $urandom_range(0, step_max);
      tmin     = '1;
      tmax     = '0;
      for (int i = 0; i < span; i++) begin
         if (ordered) vals[i] = falling ? RES_W'(65535 - acc) : RES_W'(acc);
         else vals[i] = RES_W'($urandom);
         acc += $urandom_range(0, step_max);
         if (vals[i] < tmin) tmin = vals[i];
         if (vals[i] > tmax) tmax = vals[i];
         push_write(IDX_W'(i), vals[i], TEMP_W'($urandom));
         // stray writes outside the active length
         if (span < DEPTH && $urandom_range(0, 7) == 0)
            push_write(IDX_W'($urandom_range(span, DEPTH - 1)), RES_W'($urandom),
                       TEMP_W'($urandom));
      end
      pause_at = $urandom_range(0, conversions - 1);
      for (int j = 0; j < conversions; j++) begin
         if (j == pause_at) wait_drained();
         sel = $urandom_range(0, 19);
         if (sel < 13) push_convert(RES_W'($urandom_range(tmin, tmax)));
         else if (sel < 15) push_convert(vals[$urandom_range(0, span - 1)]);
         else if (sel == 15) push_convert(RES_W'($urandom_range(0, tmin)));
         else if (sel == 16) push_convert(RES_W'($urandom_range(tmax, 65535)));
         else if (sel == 17) push_convert(RES_W'($urandom));
         else push_write(IDX_W'($urandom_range(0, span - 1)), RES_W'($urandom),
                         TEMP_W'($urandom));   // edit the live table mid-run
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // two-entry table, widest clamps, field extremes
      set_registers(2, 1'b0, TEMP_W'(-512), 10'sd511);
      push_write(8'd0, 16'd1000, TEMP_W'(-512));
      push_write(8'd1, 16'hFFFF, 10'sd511);
      push_write(8'd255, 16'd12345, 10'sd77);
      push_convert(16'd0);
      push_convert(16'd1000);
      push_convert(16'd1001);
      push_convert(16'd33000);
      push_convert(16'hFFFF);

      // empty table: always the high clamp
      set_registers(0, 1'b0, TEMP_W'(-512), 10'sd511);
      push_convert(16'd500);

      // single entry: low or high clamp, never interpolates
      set_registers(1, 1'b0, TEMP_W'(-512), 10'sd511);
      push_convert(16'd500);
      push_convert(16'd5000);

      // falling curve
      set_registers(2, 1'b1, -10'sd40, 10'sd125);
      push_write(8'd0, 16'd60000, -10'sd40);
      push_write(8'd1, 16'd0, 10'sd125);
      push_convert(16'hFFFF);
      push_convert(16'd60000);
      push_convert(16'd30001);
      push_convert(16'd0);

      // unordered table: scan stops at the first entry at or beyond the reading
      set_registers(3, 1'b0, -10'sd55, 10'sd150);
      push_write(8'd0, 16'd100, 10'sd0);
      push_write(8'd1, 16'd50, 10'sd10);
      push_write(8'd2, 16'd300, -10'sd300);
      push_convert(16'd200);
      push_convert(16'd75);
      push_convert(16'd301);

      // full table, then a length beyond the depth
      run_phase(256, 30);
      run_phase(300, 10);

      while (pushed_count < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0:       run_phase($urandom_range(17, 96), $urandom_range(20, 50));
            1, 2:    run_phase(2, $urandom_range(20, 50));
            default: run_phase($urandom_range(3, 16), $urandom_range(20, 50));
         endcase
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && temp_results_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
